### src/sepd_pkg.sv
// Shared types, constants and the 3x3 endpoint pattern test for the
// skeleton endpoint detector. No dependencies.
package sepd_pkg;

  localparam int MAX_WIDTH_DEF     = 1024;
  localparam int MAX_ENDPOINTS_DEF = 1023;
  localparam int MAX_HEIGHT        = 1024;
  localparam int PIX_W             = 8;
  localparam int COORD_W           = 10;
  localparam int CNT_W             = 10;
  localparam int ROW_W             = 10;
  localparam int CFG_DATA_W        = 11;
  localparam int CFG_IDX_W         = 8;
  localparam int OUT_DATA_W        = 40;

  localparam logic [10:0] FRAME_WIDTH_RST    = 11'd64;
  localparam logic [10:0] FRAME_HEIGHT_RST   = 11'd64;
  localparam logic [7:0]  DARK_THRESHOLD_RST = 8'd65;
  localparam logic [9:0]  ENDPOINT_LIMIT_RST = 10'd500;

  // Window holds row r, column c at bit r*3+c; a shift keeps columns 0 and 1.
  localparam logic [8:0] WIN_KEEP  = 9'h0DB;
  localparam logic [8:0] WIN_RESET = 9'h1FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 8'd0,
    REG_FRAME_HEIGHT   = 8'd1,
    REG_DARK_THRESHOLD = 8'd2,
    REG_ENDPOINT_LIMIT = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic               is_endpoint;
    logic [COORD_W-1:0] ep_x;
    logic [COORD_W-1:0] ep_y;
    logic [CNT_W-1:0]   ep_index;
    logic               frame_done;
    logic [CNT_W-1:0]   total_endpoints;
  } result_t;

  // Neighbor order p0 center, p1 N, p2 NE, p3 E, p4 SE, p5 S, p6 SW, p7 W, p8 NW.
  localparam logic [8:0] ZERO_NEED [0:7] = '{
    9'h021, 9'h081, 9'h003, 9'h009, 9'h041, 9'h101, 9'h005, 9'h011
  };
  localparam logic [8:0] ONE_NEED [0:7] = '{
    9'h18E, 9'h03E, 9'h0F8, 9'h1E2, 9'h1BE, 9'h0FE, 9'h1FA, 9'h1EE
  };

  function automatic logic is_endpoint_win(input logic [8:0] w);
    logic [8:0] p;
    logic       hit;
    p   = {w[0], w[3], w[6], w[7], w[8], w[5], w[2], w[1], w[4]};
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (((p & ZERO_NEED[i]) == 9'd0) && ((p & ONE_NEED[i]) == ONE_NEED[i])) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

### src/sepd_line_mem.sv
// Line store for the endpoint detector: one word per column holding the
// upper and middle row bits. Synchronous, one read and one write port.
module sepd_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [1:0]    rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [1:0]    wr_data_i
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/sepd_out_fifo.sv
// Three-entry result queue that decouples the detector from the output
// stream. Depends on sepd_pkg for the result struct.
module sepd_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sepd_pkg::result_t push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output sepd_pkg::result_t data_o,
  output logic [1:0]        count_o
);
  import sepd_pkg::*;

  result_t    mem [3];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign do_pop = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == 2'd2) ? 2'd0 : wr_ptr_q + 2'd1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == 2'd2) ? 2'd0 : rd_ptr_q + 2'd1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem[rd_ptr_q];
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd3) || do_pop)
    else $error("result queue overflow");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3 || wr_ptr_q == rd_ptr_q)
    else $error("result queue pointers disagree with count");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q != 2'd3) && (rd_ptr_q != 2'd3))
    else $error("result queue pointer out of range");

endmodule

### src/skeleton_endpoint_detector_unit.sv
// Skeleton endpoint detector, top level: scan counters, binarization,
// window and pattern test. Uses sepd_pkg, sepd_line_mem, sepd_out_fifo.
//
// Usage: grayscale pixels enter on the s_axis channel in raster order, one
// request per pixel (tdata[7:0]). Each pixel below dark_threshold counts as
// background. A 3x3 window is built from a two-row line store and the current
// column; every interior center matching one of the eight endpoint patterns
// yields a result on m_axis with its column, row and index. The frame's last
// pixel yields a result with tlast set (frame_done), carrying the final count.
// Other pixels yield no result. Endpoints past endpoint_limit (capped at
// MAX_ENDPOINTS) are dropped.
// Throughput: one pixel per cycle while the result queue has room. A pixel
// reads the line store in its accept cycle and is tested and written back in
// the next cycle; its result is then registered in the queue before m_axis.
// Back-pressure: results wait in a three-entry queue; s_axis_tready drops
// only when the queue plus the pixel in flight could overfill it.
// Reset: counters, window (all background), queue and registers return to
// defaults (64x64, threshold 65, limit 500); line stores are not cleared,
// entries read before they are written feed only the first two rows, which
// are never centers.
// Configuration: cfg_ready_o is always high; write only while idle.
module skeleton_endpoint_detector_unit #(
  parameter int MAX_WIDTH     = sepd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_ENDPOINTS = sepd_pkg::MAX_ENDPOINTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: pixel_value[7:0]
  input  logic [sepd_pkg::PIX_W-1:0]       s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: ep_x[9:0], ep_y[19:10], ep_index[29:20], total_endpoints[39:30]
  output logic [sepd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // tuser: is_endpoint
  output logic                             m_axis_tuser,
  // tlast: frame_done
  output logic                             m_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sepd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sepd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import sepd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // Configuration registers
  logic [10:0]      frame_width_q;
  logic [10:0]      frame_height_q;
  logic [7:0]       dark_threshold_q;
  logic [CNT_W-1:0] endpoint_limit_q;

  // Scan state (stage 0)
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // Stage 1: pixel whose line-store read is in flight
  logic             s1_valid_q;
  logic [CW-1:0]    s1_col_q;
  logic [ROW_W-1:0] s1_row_q;
  logic             s1_bg_q;
  logic             s1_center_q;
  logic             s1_done_q;

  logic [8:0]       win_q, win_d;
  logic [CNT_W-1:0] ep_count_q, ep_count_d;

  logic [12:0]      fw_ext;
  logic [10:0]      fh;
  logic [CW-1:0]    col_last;
  logic [ROW_W-1:0] row_last;
  logic [CNT_W-1:0] limit_eff;
  logic             accept;
  logic             col_wrap, row_wrap;
  logic             bg;
  logic [1:0]       rd_word;
  logic             up_bit, mid_bit;
  logic             hit, found;
  logic             push;
  result_t          res;
  result_t          out_res;
  logic             out_valid;
  logic [1:0]       q_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= FRAME_WIDTH_RST;
      frame_height_q   <= FRAME_HEIGHT_RST;
      dark_threshold_q <= DARK_THRESHOLD_RST;
      endpoint_limit_q <= ENDPOINT_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:    frame_width_q    <= cfg_data_i;
        REG_FRAME_HEIGHT:   frame_height_q   <= cfg_data_i;
        REG_DARK_THRESHOLD: dark_threshold_q <= cfg_data_i[7:0];
        REG_ENDPOINT_LIMIT: endpoint_limit_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size: width into [3, MAX_WIDTH], height into [3, MAX_HEIGHT]
  assign fw_ext = {2'b00, frame_width_q};
  assign fh     = frame_height_q;

  always_comb begin
    priority if (fw_ext < 13'd3) begin
      col_last = CW'(2);
    end else if (fw_ext > 13'(MAX_WIDTH)) begin
      col_last = CW'(MAX_WIDTH - 1);
    end else begin
      col_last = CW'(fw_ext - 13'd1);
    end
  end

  always_comb begin
    priority if (fh < 11'd3) begin
      row_last = ROW_W'(2);
    end else if (fh > 11'(MAX_HEIGHT)) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(fh - 11'd1);
    end
  end

  // Cap the endpoint limit at MAX_ENDPOINTS
  assign limit_eff = (int'(endpoint_limit_q) < MAX_ENDPOINTS) ? endpoint_limit_q
                                                              : CNT_W'(MAX_ENDPOINTS);

  // Hold input off when the queue plus the pixel in flight could fill it
  assign s_axis_tready = (q_count < 2'd2) || ((q_count == 2'd2) && !s1_valid_q);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign bg       = (s_axis_tdata < dark_threshold_q);
  assign col_wrap = (col_q >= col_last);
  assign row_wrap = (row_q >= row_last);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q    <= col_q;
      s1_row_q    <= row_q;
      s1_bg_q     <= bg;
      s1_center_q <= (col_q >= CW'(2)) && (row_q >= ROW_W'(2));
      s1_done_q   <= col_wrap && row_wrap;
    end
  end

  // Read in the accept cycle, write back in the next cycle. The same column
  // is read again no sooner than one row (at least three pixels) later, so
  // no forwarding path is needed.
  sepd_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_word),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({rd_word[0], s1_bg_q})
  );

  // Word layout: [1] upper row, [0] middle row
  assign up_bit  = rd_word[1];
  assign mid_bit = rd_word[0];

  always_comb begin
    win_d = win_q;
    if (s1_valid_q) begin
      win_d = ((win_q >> 1) & WIN_KEEP) | {s1_bg_q, 2'b00, mid_bit, 2'b00, up_bit, 2'b00};
    end
  end

  assign hit   = s1_valid_q && s1_center_q && is_endpoint_win(win_d);
  assign found = hit && (ep_count_q < limit_eff);
  assign push  = s1_valid_q && (found || s1_done_q);

  always_comb begin
    ep_count_d = ep_count_q;
    if (s1_valid_q) begin
      priority if (s1_done_q) begin
        ep_count_d = '0;
      end else if (found) begin
        ep_count_d = ep_count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= WIN_RESET;
      ep_count_q <= '0;
    end else begin
      win_q      <= win_d;
      ep_count_q <= ep_count_d;
    end
  end

  always_comb begin
    res.is_endpoint     = found;
    res.ep_x            = found ? COORD_W'(s1_col_q - CW'(1)) : '0;
    res.ep_y            = found ? COORD_W'(s1_row_q - ROW_W'(1)) : '0;
    res.ep_index        = found ? ep_count_q : '0;
    res.frame_done      = s1_done_q;
    res.total_endpoints = found ? ep_count_q + CNT_W'(1) : ep_count_q;
  end

  sepd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .pop_i       (m_axis_tready),
    .valid_o     (out_valid),
    .data_o      (out_res),
    .count_o     (q_count)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.is_endpoint;
  assign m_axis_tlast  = out_res.frame_done;
  assign m_axis_tdata  = {out_res.total_endpoints, out_res.ep_index,
                          out_res.ep_y, out_res.ep_x};

  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_valid_q) |-> (col_q != s1_col_q))
    else $error("line store read and write hit the same column");

  a_index_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res.is_endpoint) |-> (res.total_endpoints == res.ep_index + CNT_W'(1)))
    else $error("endpoint index and running total disagree");

  a_stage_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(accept))
    else $error("stage 1 active without an accepted pixel");

endmodule
